/* rtl/pspm_pkg.sv */
package pspm_pkg;

    localparam int PARTICLE_SLOTS_DEF  = 64;
    localparam int TRANSFORM_SLOTS_DEF = 64;
    localparam int LIST_COUNT_DEF      = 16;

    localparam int CNT_W   = 7;
    localparam int EFF_W   = 16;
    localparam int USERS_W = 16;
    localparam int FIELD_SLOT_W = 6;
    localparam int FIELD_LIST_W = 4;

    typedef enum logic [1:0] {
        REQ_MAKE   = 2'd0,
        REQ_EJECT  = 2'd1,
        REQ_MAKE_T = 2'd2,
        REQ_INIT   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_BAD      = 2'd3
    } t_status;

    localparam logic CFG_PCOUNT = 1'b0;
    localparam logic CFG_TCOUNT = 1'b1;

endpackage

/* rtl/pspm_ram.sv */
module pspm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/particle_slot_pool_manager_top.sv */
// Slot pool manager for particles and shared transforms.
// Requests arrive on the s_axis channel, one per transfer; every request gives
// exactly one result transfer on m_axis holding status, slot, effect id, the
// transform-freed flag and the four usage counters after the request.
// Config writes (index 0 particle pool count, 1 transform pool count) come on
// the cfg channel, are always ready, and take effect at the next init request.
// A small sequencer works around memories with registered reads, one access
// per memory per cycle. States per request: make transform S_MT, make particle
//   S_MK_R, S_MK_C, S_MK_W (and S_MK_W2 when inserted after a slot), eject
//   S_EJ_L, S_EJ_W walking the list (walk bounded by PARTICLE_SLOTS), S_EJ_U, S_EJ_F,
//   init one entry per cycle over max(PARTICLE_SLOTS, TRANSFORM_SLOTS) entries;
//   rejected requests end early. Each goes through S_OUT. The list walk of eject dominates the average rate.
// s_axis_tready is low while a request is in progress and while a result is
// held; the result register stays until m_axis_tready takes it, and the next
// request is taken from the cycle after that transfer.
// Reset empties both pools and all lists, zeroes counters and effect counter
// and sets both pool counts to 64. Until the first init every make reports
// pool empty. Live bits are flops; transform user counts sit in memory and
// are cleared by the init pass.
module particle_slot_pool_manager_top
    import pspm_pkg::*;
#(
    parameter int PARTICLE_SLOTS  = PARTICLE_SLOTS_DEF,
    parameter int TRANSFORM_SLOTS = TRANSFORM_SLOTS_DEF,
    parameter int LIST_COUNT      = LIST_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: req_type[1:0] slot[7:2] after_valid[8] list_index[12:9]
    //        use_generator[13] gen_transform_valid[14] gen_transform[20:15]
    //        gen_effect_id[36:21], zero fill [39:37]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    // tdata: status[1:0] result_slot[7:2] effect_id[23:8] transform_freed[24]
    //        particles_used[31:25] particles_peak[38:32] transforms_used[45:39]
    //        transforms_peak[52:46], zero fill [55:53]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    localparam int PW = $clog2(PARTICLE_SLOTS);
    localparam int TW = $clog2(TRANSFORM_SLOTS);
    localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam int PN = PW + 1;   // particle pointer with nil
    localparam int TN = TW + 1;
    localparam int FW = LW + TN;  // particle info: list, transform
    localparam logic [PN-1:0] P_NIL = PN'(PARTICLE_SLOTS);
    localparam logic [TN-1:0] T_NIL = TN'(TRANSFORM_SLOTS);
    localparam int PCW = $clog2(PARTICLE_SLOTS + 1);
    localparam int TCW = $clog2(TRANSFORM_SLOTS + 1);
    localparam int IW  = (PCW > TCW) ? PCW : TCW;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_INIT  = 12'b000000000010,
        S_MK_R  = 12'b000000000100,  // checks, read after-slot link and info
        S_MK_C  = 12'b000000001000,  // transform check, take free slot
        S_MK_W  = 12'b000000010000,  // write new link
        S_MK_W2 = 12'b000000100000,  // write after-slot link
        S_EJ_L  = 12'b000001000000,  // fetch list and transform of slot
        S_EJ_W  = 12'b000010000000,  // walk list
        S_EJ_U  = 12'b000100000000,  // unlink
        S_EJ_F  = 12'b001000000000,  // free particle, release transform
        S_MT    = 12'b010000000000,  // read transform link
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    // config registers
    logic [6:0] r_pcount, r_tcount;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= 7'd64;
            r_tcount <= 7'd64;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PCOUNT) r_pcount <= i_cfg_data;
            if (i_cfg_index == CFG_TCOUNT) r_tcount <= i_cfg_data;
        end
    end

    // request fields
    logic [5:0]  r_slot;
    logic        r_after, r_gen, r_tv;
    logic [3:0]  r_list_in;
    logic [5:0]  r_gtf;
    logic [15:0] r_geff;

    // per-slot flops
    logic [PARTICLE_SLOTS-1:0]  r_live;
    logic [PN-1:0]              r_heads   [LIST_COUNT];
    logic [PN-1:0]              r_pfree;
    logic [TN-1:0]              r_tfree;
    logic [EFF_W-1:0]           r_eff_cnt;
    logic [CNT_W-1:0]           r_pu, r_pp, r_tu, r_tp;

    // working registers
    logic [PN-1:0]  r_cur, r_prev, r_np, r_nxt;
    logic [LW-1:0]  r_list;
    logic [TN-1:0]  r_ptfc;
    logic [IW-1:0]  r_idx;
    logic [PW:0]    r_steps;
    logic [1:0]     r_st;
    logic [5:0]     r_rslot;
    logic [15:0]    r_reff;
    logic           r_freed;
    logic [55:0]    r_out;
    logic           r_ovalid;

    // particle link memory
    logic          p_we;
    logic [PW-1:0] p_wa, p_ra;
    logic [PN-1:0] p_wd, p_rd;
    pspm_ram #(.WIDTH(PN), .DEPTH(PARTICLE_SLOTS)) u_plink (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd)
    );
    // particle info memory: list in the upper bits, transform in the lower
    logic          f_we;
    logic [PW-1:0] f_wa, f_ra;
    logic [FW-1:0] f_wd, f_rd;
    pspm_ram #(.WIDTH(FW), .DEPTH(PARTICLE_SLOTS)) u_pinfo (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_wa), .i_wdata(f_wd),
        .i_raddr(f_ra), .o_rdata(f_rd)
    );
    // transform link memory
    logic          t_we;
    logic [TW-1:0] t_wa, t_ra;
    logic [TN-1:0] t_wd, t_rd;
    pspm_ram #(.WIDTH(TN), .DEPTH(TRANSFORM_SLOTS)) u_tlink (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rd)
    );
    // transform user count memory
    logic               u_we;
    logic [TW-1:0]      u_wa, u_ra;
    logic [USERS_W-1:0] u_wd, u_rd;
    pspm_ram #(.WIDTH(USERS_W), .DEPTH(TRANSFORM_SLOTS)) u_tusers (
        .i_clk(i_clk), .i_we(u_we), .i_waddr(u_wa), .i_wdata(u_wd),
        .i_raddr(u_ra), .o_rdata(u_rd)
    );

    // clamped init counts
    logic [IW-1:0] np_cnt, nt_cnt;
    assign np_cnt = (32'(r_pcount) > PARTICLE_SLOTS) ? IW'(PARTICLE_SLOTS) : IW'(r_pcount);
    assign nt_cnt = (32'(r_tcount) > TRANSFORM_SLOTS) ? IW'(TRANSFORM_SLOTS) : IW'(r_tcount);

    // checks for make particle (slot/transform widened against the pool)
    logic          slot_ok, tf_ok, tf_bad, list_ok, tf_rel;
    logic [PW-1:0] slot_ix;
    logic [TW-1:0] gtf_ix;
    logic [LW-1:0] mk_list;
    logic [TN-1:0] mk_tf;
    assign slot_ix = PW'(r_slot);
    assign gtf_ix  = TW'(r_gtf);
    assign slot_ok = (32'(r_slot) < PARTICLE_SLOTS) && r_live[slot_ix];
    assign tf_ok   = (32'(r_gtf) < TRANSFORM_SLOTS) && (u_rd != '0)
                     && (u_rd != {USERS_W{1'b1}});
    assign tf_bad  = r_gen && r_tv && !tf_ok;
    assign mk_list = r_after ? f_rd[FW-1:TN] : LW'(r_list_in);
    assign mk_tf   = (r_gen && r_tv) ? TN'(gtf_ix) : T_NIL;
    assign list_ok = r_after ? 1'b1 : (32'(r_list_in) < LIST_COUNT);
    // transform of the ejected particle still has users
    assign tf_rel  = (r_ptfc != T_NIL) && (u_rd != '0);

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    // memory port control
    always_comb begin
        p_we = 1'b0; p_wa = r_np[PW-1:0]; p_wd = r_nxt; p_ra = r_cur[PW-1:0];
        t_we = 1'b0; t_wa = r_idx[TW-1:0]; t_wd = T_NIL; t_ra = r_tfree[TW-1:0];
        f_we = 1'b0; f_wa = r_np[PW-1:0]; f_wd = {mk_list, mk_tf}; f_ra = slot_ix;
        u_we = 1'b0; u_wa = gtf_ix; u_wd = u_rd + 1'b1; u_ra = gtf_ix;
        case (r_state)
            S_INIT: begin
                p_we = r_idx < np_cnt;
                p_wa = r_idx[PW-1:0];
                p_wd = (r_idx + 1'b1 < np_cnt) ? PN'(r_idx + 1'b1) : P_NIL;
                t_we = r_idx < nt_cnt;
                t_wd = (r_idx + 1'b1 < nt_cnt) ? TN'(r_idx + 1'b1) : T_NIL;
                u_we = 32'(r_idx) < TRANSFORM_SLOTS;
                u_wa = r_idx[TW-1:0];
                u_wd = '0;
            end
            S_IDLE: begin
                p_ra = r_pfree[PW-1:0];
                f_ra = PW'(s_axis_tdata[7:2]);
            end
            S_MK_R: p_ra = slot_ix;
            S_MK_C: begin
                f_we = !tf_bad;
                u_we = r_gen && r_tv && !tf_bad;
            end
            S_MK_W: p_we = 1'b1;
            S_MK_W2: begin
                p_we = 1'b1; p_wa = slot_ix; p_wd = r_np;
            end
            S_EJ_U: begin
                p_we = (r_prev != P_NIL);
                p_wa = r_prev[PW-1:0];
                p_wd = p_rd;
                u_ra = r_ptfc[TW-1:0];
            end
            S_EJ_F: begin
                p_we = 1'b1; p_wa = r_cur[PW-1:0]; p_wd = r_pfree;
                u_we = tf_rel; u_wa = r_ptfc[TW-1:0]; u_wd = u_rd - 1'b1;
                t_we = tf_rel && (u_rd == USERS_W'(1));
                t_wa = r_ptfc[TW-1:0]; t_wd = r_tfree;
            end
            S_MT: begin
                u_we = r_idx[0]; u_wa = r_tfree[TW-1:0]; u_wd = USERS_W'(1);
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_live    <= '0;
            r_pfree   <= P_NIL;
            r_tfree   <= T_NIL;
            r_eff_cnt <= '0;
            r_pu <= '0; r_pp <= '0; r_tu <= '0; r_tp <= '0;
            for (int i = 0; i < LIST_COUNT; i++) r_heads[i] <= P_NIL;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (s_axis_tvalid && !r_ovalid) begin
                    r_slot <= s_axis_tdata[7:2];
                    r_after <= s_axis_tdata[8]; r_list_in <= s_axis_tdata[12:9];
                    r_gen <= s_axis_tdata[13]; r_tv <= s_axis_tdata[14];
                    r_gtf <= s_axis_tdata[20:15]; r_geff <= s_axis_tdata[36:21];
                    r_st <= ST_OK; r_rslot <= '0; r_reff <= '0; r_freed <= 1'b0;
                    r_idx <= '0; r_steps <= '0; r_prev <= P_NIL;
                    r_np <= r_pfree;
                    case (t_req'(s_axis_tdata[1:0]))
                        REQ_MAKE: r_state <= S_MK_R;
                        REQ_EJECT: begin
                            if ((32'(s_axis_tdata[7:2]) >= PARTICLE_SLOTS)
                                || !r_live[PW'(s_axis_tdata[7:2])]) begin
                                r_st <= ST_NOTFOUND; r_state <= S_OUT;
                            end else begin
                                r_state <= S_EJ_L;
                            end
                        end
                        REQ_MAKE_T: begin
                            if (r_tfree == T_NIL) begin
                                r_st <= ST_EMPTY; r_state <= S_OUT;
                            end else r_state <= S_MT;
                        end
                        default: begin
                            r_live <= '0;
                            r_pu <= '0; r_pp <= '0; r_tu <= '0; r_tp <= '0;
                            for (int i = 0; i < LIST_COUNT; i++) r_heads[i] <= P_NIL;
                            r_state <= S_INIT;
                        end
                    endcase
                end
                S_INIT: begin
                    r_idx <= r_idx + 1'b1;
                    if (32'(r_idx) == ((PARTICLE_SLOTS > TRANSFORM_SLOTS) ?
                                       PARTICLE_SLOTS : TRANSFORM_SLOTS) - 1) begin
                        r_pfree <= (np_cnt != '0) ? '0 : P_NIL;
                        r_tfree <= (nt_cnt != '0) ? '0 : T_NIL;
                        r_state <= S_OUT;
                    end
                end
                S_MK_R: begin
                    // free head link read from idle arrives on p_rd
                    r_nxt <= p_rd;
                    if (r_pfree == P_NIL) begin
                        r_st <= ST_EMPTY; r_state <= S_OUT;
                    end else if (r_after && !slot_ok) begin
                        r_st <= ST_BAD; r_state <= S_OUT;
                    end else if (!list_ok) begin
                        r_st <= ST_BAD; r_state <= S_OUT;
                    end else begin
                        r_state <= S_MK_C;
                    end
                end
                S_MK_C: begin
                    // p_rd holds link of the after-slot, f_rd its list, u_rd the users
                    if (tf_bad) begin
                        r_st <= ST_BAD; r_state <= S_OUT;
                    end else begin
                        r_pfree <= r_nxt;
                        r_pu <= r_pu + 1'b1;
                        if (r_pp < r_pu + 1'b1) r_pp <= r_pu + 1'b1;
                        if (r_gen) r_reff <= r_geff;
                        else begin
                            r_eff_cnt <= r_eff_cnt + 1'b1;
                            r_reff <= r_eff_cnt + 1'b1;
                        end
                        r_nxt <= r_after ? p_rd : r_heads[mk_list];
                        if (!r_after) r_heads[mk_list] <= r_np;
                        r_live[r_np[PW-1:0]] <= 1'b1;
                        r_rslot <= 6'(r_np);
                        r_state <= S_MK_W;
                    end
                end
                S_MK_W: r_state <= r_after ? S_MK_W2 : S_OUT;
                S_MK_W2: r_state <= S_OUT;
                S_EJ_L: begin
                    r_list <= f_rd[FW-1:TN];
                    r_ptfc <= f_rd[TN-1:0];
                    r_cur <= r_heads[f_rd[FW-1:TN]];
                    r_state <= S_EJ_W;
                end
                S_EJ_W: begin
                    // p_ra = r_cur issued this cycle; data is taken on the pass with r_idx[0] set
                    if (r_cur == P_NIL || 32'(r_steps) >= PARTICLE_SLOTS) begin
                        r_st <= ST_NOTFOUND; r_state <= S_OUT;
                    end else if (r_cur == PN'(r_slot)) begin
                        r_state <= S_EJ_U;
                    end else if (r_idx[0]) begin
                        r_prev <= r_cur; r_cur <= p_rd;
                        r_steps <= r_steps + 1'b1;
                        r_idx <= '0;
                    end else r_idx <= IW'(1);
                end
                S_EJ_U: begin
                    if (r_prev == P_NIL) r_heads[r_list] <= p_rd;
                    r_state <= S_EJ_F;
                end
                S_EJ_F: begin
                    if (tf_rel && (u_rd == USERS_W'(1))) begin
                        r_tfree <= r_ptfc;
                        if (r_tu != '0) r_tu <= r_tu - 1'b1;
                        r_freed <= 1'b1;
                    end
                    r_live[r_cur[PW-1:0]] <= 1'b0;
                    r_pfree <= r_cur;
                    if (r_pu != '0) r_pu <= r_pu - 1'b1;
                    r_rslot <= 6'(r_cur);
                    r_state <= S_OUT;
                end
                S_MT: begin
                    if (r_idx[0]) begin
                        r_tfree <= t_rd;
                        r_tu <= r_tu + 1'b1;
                        if (r_tp < r_tu + 1'b1) r_tp <= r_tu + 1'b1;
                        r_rslot <= 6'(r_tfree);
                        r_state <= S_OUT;
                    end else r_idx <= IW'(1);
                end
                S_OUT: begin
                    r_out <= {3'b0, r_tp, r_tu, r_pp, r_pu,
                              (r_st == ST_OK) & r_freed,
                              (r_st == ST_OK) ? r_reff : 16'd0,
                              (r_st == ST_OK) ? r_rslot : 6'd0, r_st};
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // usage never exceeds peak
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pu <= r_pp) && (r_tu <= r_tp)) else $error("usage above peak");
    // no new request while a result is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready) else $error("ready while result held");
    // result is valid in the cycle after the output state
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_ovalid) else $error("result lost");
endmodule
